FILE: design/cfa_pkg.sv
// Shared types, constants and functions of the chunked frame assembler.
// No dependencies; every other file of the block depends on this package.
package cfa_pkg;

    localparam int unsigned PANEL_WIDTH  = 960;
    localparam int unsigned PANEL_HEIGHT = 540;

    localparam int unsigned OFFSET_W = 18;
    localparam int unsigned COORD_W  = 10;
    localparam int unsigned CRC_W    = 32;

    localparam logic [OFFSET_W:0] CAPACITY = (OFFSET_W + 1)'(PANEL_WIDTH * PANEL_HEIGHT / 2);
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_FULL   = 2'd0;
    localparam logic [1:0] OP_REGION = 2'd1;
    localparam logic [1:0] OP_CHUNK  = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [2:0] ST_PUSH_FULL   = 3'd0;
    localparam logic [2:0] ST_PUSH_REGION = 3'd1;
    localparam logic [2:0] ST_CRC_FAIL    = 3'd2;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd3;
    localparam logic [2:0] ST_DECODE_ERR  = 3'd4;

    localparam logic [1:0] CMD_GROUP = 2'd0;
    localparam logic [1:0] CMD_ERROR = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic [6:0] CLS_PAD = 7'd64;
    localparam logic [6:0] CLS_BAD = 7'd65;

    typedef struct packed {
        logic [1:0]          code;
        logic                restart;
        logic [23:0]         bytes;
        logic [1:0]          nbytes;
        logic [OFFSET_W-1:0] offset;
        logic                id_ok;
        logic                crc_check;
        logic [CRC_W-1:0]    crc_target;
        logic                region;
        logic [COORD_W-1:0]  box_x;
        logic [COORD_W-1:0]  box_y;
        logic [COORD_W-1:0]  box_w;
        logic [COORD_W-1:0]  box_h;
        logic                size_mismatch;
    } t_cmd;

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] v;
        if (c inside {[8'h41:8'h5A]}) begin
            v = 7'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else if (c == 8'h3D) begin
            v = CLS_PAD;
        end else begin
            v = CLS_BAD;
        end
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

FILE: design/cfa_if.sv
// Handshake channels of the chunked frame assembler: input items and results.
// Depends on cfa_pkg for field widths.
interface cfa_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [31:0]                  frame_id;
    logic [31:0]                  expected_crc;
    logic [cfa_pkg::COORD_W-1:0]  origin_x;
    logic [cfa_pkg::COORD_W-1:0]  origin_y;
    logic [cfa_pkg::COORD_W-1:0]  extent_w;
    logic [cfa_pkg::COORD_W-1:0]  extent_h;
    logic [7:0]                   code_char;
    logic                         chunk_last;

    modport source (output valid, operation, frame_id, expected_crc, origin_x, origin_y,
                    extent_w, extent_h, code_char, chunk_last, input ready);
    modport sink   (input valid, operation, frame_id, expected_crc, origin_x, origin_y,
                    extent_w, extent_h, code_char, chunk_last, output ready);
endinterface

interface cfa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [cfa_pkg::OFFSET_W-1:0] write_address;
    logic [7:0]                   write_data;
    logic [2:0]                   status;
    logic                         size_mismatch;
    logic [cfa_pkg::COORD_W-1:0]  push_x;
    logic [cfa_pkg::COORD_W-1:0]  push_y;
    logic [cfa_pkg::COORD_W-1:0]  push_w;
    logic [cfa_pkg::COORD_W-1:0]  push_h;
    logic [cfa_pkg::OFFSET_W-1:0] byte_count;
    logic                         last;

    modport source (output valid, kind, write_address, write_data, status, size_mismatch,
                    push_x, push_y, push_w, push_h, byte_count, last, input ready);
    modport sink   (input valid, kind, write_address, write_data, status, size_mismatch,
                    push_x, push_y, push_w, push_h, byte_count, last, output ready);
endinterface

FILE: design/chunked_frame_assembler_unit.sv
// Top level of the chunked frame assembler: front end, command queue, back end.
// Depends on cfa_pkg, cfa_if, cfa_front, cfa_queue and cfa_back.
//
//   channel    | dir | handshake      | moves
//   i_item     | in  | valid / ready  | begin, chunk character or end item
//   o_result   | out | valid / ready  | buffer byte write or status / push
//
// One item is taken every cycle while the four-entry command queue has room.
// A completed base64 group leaves the back end as one to three byte writes, one
// per cycle while o_result is ready, each folded into the CRC in that cycle.
// Items pass a queue slot, then the output register. Reset is synchronous, no sweep.
// A stalled output register holds its transfer; the queue lets the front run on.
module chunked_frame_assembler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfa_in_if.sink    i_item,
    cfa_out_if.source o_result
);
    import cfa_pkg::*;

    logic push, q_full, pop, q_valid;
    t_cmd cmd_in, cmd_head;

    cfa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    cfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (cmd_head)
    );

    cfa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (cmd_head),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

FILE: design/cfa_front.sv
// Front end: accepts items, tracks the frame, decodes base64 groups, issues commands.
// Depends on cfa_pkg and cfa_in_if.
module cfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfa_in_if.sink        i_item,
    input  logic          i_q_full,
    output logic          o_push,
    output cfa_pkg::t_cmd o_cmd
);
    import cfa_pkg::*;

    logic                r_receiving, n_receiving;
    logic [31:0]         r_active_id, n_active_id;
    logic [CRC_W-1:0]    r_crc_target, n_crc_target;
    logic                r_region, n_region;
    logic [COORD_W-1:0]  r_box_x, n_box_x, r_box_y, n_box_y;
    logic [COORD_W-1:0]  r_box_w, n_box_w, r_box_h, n_box_h;
    logic [OFFSET_W:0]   r_expect, n_expect;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic                r_fresh, n_fresh;
    logic [17:0]         r_group, n_group;
    logic [1:0]          r_fill, n_fill;
    logic [1:0]          r_pad, n_pad;

    logic                accept;
    logic [6:0]          cls;
    logic                pad_now;
    logic [5:0]          sext;
    logic [1:0]          pad_next;
    logic [1:0]          nb;
    logic [OFFSET_W:0]   end_offset;
    logic [2*COORD_W-1:0] area;

    assign i_item.ready = !i_q_full;
    assign accept = i_item.valid && i_item.ready;

    assign cls        = classify(i_item.code_char);
    assign pad_now    = (cls == CLS_PAD);
    assign sext       = pad_now ? 6'd0 : cls[5:0];
    assign pad_next   = r_pad + {1'b0, pad_now};
    assign nb         = 2'd3 - pad_next;
    assign end_offset = {1'b0, r_offset} + {{(OFFSET_W - 1){1'b0}}, nb};
    assign area       = i_item.extent_w * i_item.extent_h;

    always_comb begin
        n_receiving  = r_receiving;
        n_active_id  = r_active_id;
        n_crc_target = r_crc_target;
        n_region     = r_region;
        n_box_x      = r_box_x;
        n_box_y      = r_box_y;
        n_box_w      = r_box_w;
        n_box_h      = r_box_h;
        n_expect     = r_expect;
        n_offset     = r_offset;
        n_fresh      = r_fresh;
        n_group      = r_group;
        n_fill       = r_fill;
        n_pad        = r_pad;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.offset = r_offset;
        o_cmd.restart = r_fresh;

        if (accept) begin
            case (i_item.operation)
                OP_FULL, OP_REGION: begin
                    n_receiving  = 1'b1;
                    n_active_id  = i_item.frame_id;
                    n_crc_target = i_item.expected_crc;
                    n_region     = (i_item.operation == OP_REGION);
                    if (i_item.operation == OP_REGION) begin
                        n_box_x  = i_item.origin_x;
                        n_box_y  = i_item.origin_y;
                        n_box_w  = i_item.extent_w;
                        n_box_h  = i_item.extent_h;
                        n_expect = (OFFSET_W + 1)'(area >> 1);
                    end else begin
                        n_box_x  = '0;
                        n_box_y  = '0;
                        n_box_w  = COORD_W'(PANEL_WIDTH);
                        n_box_h  = COORD_W'(PANEL_HEIGHT);
                        n_expect = CAPACITY;
                    end
                    n_offset = '0;
                    n_fresh  = 1'b1;
                    n_group  = '0;
                    n_fill   = '0;
                    n_pad    = '0;
                end
                OP_CHUNK: begin
                    if (r_receiving && i_item.frame_id == r_active_id) begin
                        if (cls == CLS_BAD || (pad_now && r_fill < 2'd2)
                            || (!pad_now && r_pad != 2'd0)
                            || (r_fill < 2'd3 && i_item.chunk_last)
                            || (r_fill == 2'd3 && pad_next != 2'd0 && !i_item.chunk_last)
                            || (r_fill == 2'd3 && end_offset > CAPACITY)) begin
                            n_receiving = 1'b0;
                            n_group     = '0;
                            n_fill      = '0;
                            n_pad       = '0;
                            o_push      = 1'b1;
                            o_cmd.code  = CMD_ERROR;
                        end else if (r_fill < 2'd3) begin
                            n_group = {r_group[11:0], sext};
                            n_fill  = r_fill + 2'd1;
                            n_pad   = pad_next;
                        end else begin
                            n_offset     = end_offset[OFFSET_W-1:0];
                            n_fresh      = 1'b0;
                            n_group      = '0;
                            n_fill       = '0;
                            n_pad        = '0;
                            o_push       = 1'b1;
                            o_cmd.code   = CMD_GROUP;
                            o_cmd.bytes  = {r_group, sext};
                            o_cmd.nbytes = nb;
                        end
                    end
                end
                OP_END: begin
                    if (r_receiving) begin
                        n_receiving         = 1'b0;
                        n_group             = '0;
                        n_fill              = '0;
                        n_pad               = '0;
                        o_push              = 1'b1;
                        o_cmd.code          = CMD_END;
                        o_cmd.id_ok         = (i_item.frame_id == r_active_id);
                        o_cmd.crc_check     = (r_crc_target != '0);
                        o_cmd.crc_target    = r_crc_target;
                        o_cmd.region        = r_region;
                        o_cmd.box_x         = r_box_x;
                        o_cmd.box_y         = r_box_y;
                        o_cmd.box_w         = r_box_w;
                        o_cmd.box_h         = r_box_h;
                        o_cmd.size_mismatch = ({1'b0, r_offset} != r_expect);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_active_id  <= '0;
            r_crc_target <= '0;
            r_region     <= 1'b0;
            r_box_x      <= '0;
            r_box_y      <= '0;
            r_box_w      <= COORD_W'(PANEL_WIDTH);
            r_box_h      <= COORD_W'(PANEL_HEIGHT);
            r_expect     <= CAPACITY;
            r_offset     <= '0;
            r_fresh      <= 1'b1;
            r_group      <= '0;
            r_fill       <= '0;
            r_pad        <= '0;
        end else begin
            r_receiving  <= n_receiving;
            r_active_id  <= n_active_id;
            r_crc_target <= n_crc_target;
            r_region     <= n_region;
            r_box_x      <= n_box_x;
            r_box_y      <= n_box_y;
            r_box_w      <= n_box_w;
            r_box_h      <= n_box_h;
            r_expect     <= n_expect;
            r_offset     <= n_offset;
            r_fresh      <= n_fresh;
            r_group      <= n_group;
            r_fill       <= n_fill;
            r_pad        <= n_pad;
        end
    end

endmodule

FILE: design/cfa_queue.sv
// Short command queue between the front and back ends of the assembler.
// Depends on cfa_pkg for the command type and depth.
module cfa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfa_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cfa_pkg::t_cmd o_head
);
    import cfa_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_count <= r_count + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
        end
    end

endmodule

FILE: design/cfa_back.sv
// Back end: expands commands into results, folds bytes into the CRC, checks at end.
// Depends on cfa_pkg and cfa_out_if.
module cfa_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cfa_pkg::t_cmd i_cmd,
    output logic          o_pop,
    cfa_out_if.source     o_result
);
    import cfa_pkg::*;

    logic                r_valid, n_valid;
    logic [1:0]          r_idx, n_idx;
    logic [CRC_W-1:0]    r_crc, n_crc;
    logic                r_kind, n_kind;
    logic [OFFSET_W-1:0] r_addr, n_addr;
    logic [7:0]          r_data, n_data;
    logic [2:0]          r_status, n_status;
    logic                r_mism, n_mism;
    logic [COORD_W-1:0]  r_px, n_px, r_py, n_py, r_pw, n_pw, r_ph, n_ph;
    logic [OFFSET_W-1:0] r_count, n_count;
    logic                r_last, n_last;

    logic                advance;
    logic [7:0]          cur_byte;
    logic [CRC_W-1:0]    crc_base;
    logic                grp_last;

    assign advance  = !r_valid || o_result.ready;
    assign crc_base = (i_cmd.restart && r_idx == 2'd0) ? CRC_INIT : r_crc;
    assign grp_last = (r_idx + 2'd1 == i_cmd.nbytes);

    always_comb begin
        case (r_idx)
            2'd0:    cur_byte = i_cmd.bytes[23:16];
            2'd1:    cur_byte = i_cmd.bytes[15:8];
            default: cur_byte = i_cmd.bytes[7:0];
        endcase
    end

    always_comb begin
        n_valid  = r_valid;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_kind   = r_kind;
        n_addr   = r_addr;
        n_data   = r_data;
        n_status = r_status;
        n_mism   = r_mism;
        n_px     = r_px;
        n_py     = r_py;
        n_pw     = r_pw;
        n_ph     = r_ph;
        n_count  = r_count;
        n_last   = r_last;
        o_pop    = 1'b0;

        if (advance) begin
            n_valid = i_valid;
            if (i_valid) begin
                n_addr   = '0;
                n_data   = '0;
                n_status = ST_PUSH_FULL;
                n_mism   = 1'b0;
                n_px     = '0;
                n_py     = '0;
                n_pw     = '0;
                n_ph     = '0;
                n_count  = i_cmd.offset;
                n_last   = 1'b1;
                n_idx    = '0;
                o_pop    = 1'b1;
                case (i_cmd.code)
                    CMD_GROUP: begin
                        n_kind  = 1'b0;
                        n_addr  = i_cmd.offset + OFFSET_W'(r_idx);
                        n_data  = cur_byte;
                        n_count = '0;
                        n_crc   = crc_fold(crc_base, cur_byte);
                        n_last  = grp_last;
                        o_pop   = grp_last;
                        n_idx   = grp_last ? 2'd0 : r_idx + 2'd1;
                    end
                    CMD_END: begin
                        n_kind = 1'b1;
                        if (!i_cmd.id_ok) begin
                            n_status = ST_ID_MISMATCH;
                        end else if (i_cmd.crc_check
                                     && ~(i_cmd.restart ? CRC_INIT : r_crc) != i_cmd.crc_target)
                        begin
                            n_status = ST_CRC_FAIL;
                        end else begin
                            n_status = i_cmd.region ? ST_PUSH_REGION : ST_PUSH_FULL;
                            n_mism   = i_cmd.size_mismatch;
                            n_px     = i_cmd.box_x;
                            n_py     = i_cmd.box_y;
                            n_pw     = i_cmd.box_w;
                            n_ph     = i_cmd.box_h;
                        end
                    end
                    default: begin
                        n_kind   = 1'b1;
                        n_status = ST_DECODE_ERR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_addr   <= n_addr;
        r_data   <= n_data;
        r_status <= n_status;
        r_mism   <= n_mism;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pw     <= n_pw;
        r_ph     <= n_ph;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    assign o_result.valid         = r_valid;
    assign o_result.kind          = r_kind;
    assign o_result.write_address = r_addr;
    assign o_result.write_data    = r_data;
    assign o_result.status        = r_status;
    assign o_result.size_mismatch = r_mism;
    assign o_result.push_x        = r_px;
    assign o_result.push_y        = r_py;
    assign o_result.push_w        = r_pw;
    assign o_result.push_h        = r_ph;
    assign o_result.byte_count    = r_count;
    assign o_result.last          = r_last;

endmodule
